FILE: src/msa_pkg.sv
// Shared types, widths and codes for the strain statistics unit.
// Used by msa_div and multichannel_strain_stats_alert_unit; depends on nothing.
package msa_pkg;

  // Sizing
  localparam int SENSORS     = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int SENSOR_W    = 6;
  localparam int CNT_W       = 7;
  localparam int THR_W       = 16;
  localparam int SUM_W       = SAMPLE_BITS + CNT_W;
  localparam int ADDR_W      = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // Item kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_EVAL   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b1;

  // Extremes of a sample
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic [1:0]                    kind;
    logic [SENSOR_W-1:0]           sensor_index;
    logic signed [SAMPLE_BITS-1:0] strain;
  } in_item_t;

  typedef struct packed {
    logic [SENSOR_W-1:0]           sensor_out;
    logic signed [SAMPLE_BITS-1:0] peak_strain;
    logic signed [SAMPLE_BITS-1:0] trough_strain;
    logic signed [SAMPLE_BITS-1:0] mean_strain;
    logic [CNT_W-1:0]              sample_count;
    logic                          high_alert;
    logic                          empty_res;
  } out_item_t;

  // One sensor's statistics as held in memory
  typedef struct packed {
    logic [CNT_W-1:0]              cnt;
    logic signed [SUM_W-1:0]       sum;
    logic signed [SAMPLE_BITS-1:0] mn;
    logic signed [SAMPLE_BITS-1:0] mx;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{cnt: '0, sum: '0, mn: SMAX, mx: SMIN};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_RESP
  } state_t;

endpackage

FILE: src/multichannel_strain_stats_alert_unit.sv
// Top level of the per-sensor strain statistics unit with high-stress alert.
// Depends on msa_pkg, msa_ram and msa_div.
//
// Input items (in_valid / in_stall / in_data) carry a kind, a sensor index and
// a Q7.8 strain. A sample item updates the sensor's count, sum, min and max in
// the statistics memory unless the count has reached sample_limit; a clear
// item empties the sensor; an evaluate item returns one result item on
// out_valid / out_stall / out_data with peak, trough, mean (sum / count,
// truncated toward zero), count, alert and empty flags. Unknown kinds are
// dropped without a result. Write the configuration port (alert_threshold,
// sample_limit) only while the unit is idle.
// Flow: one item at a time. A clear item drops the sensor's valid bit; a
// sample item reads memory, then modifies and writes back; an evaluate item
// reads memory and, for a non-empty sensor, waits on the bit-serial divider
// before it forms its result.
// Stall: the result waits in an output register; sample and clear items keep
// flowing, and an evaluate item holds in its last cycle until that register frees.
// Reset: synchronous, active low; all sensors read as empty at once through one
// valid bit per memory entry, threshold returns to 5.0 (1280) and limit to 100.
module multichannel_strain_stats_alert_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  msa_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output msa_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [msa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int EW = $bits(msa_pkg::entry_t);

  // Configuration
  logic signed [msa_pkg::THR_W-1:0] thr_r;
  logic [msa_pkg::CNT_W-1:0]        limit_r;

  // Control
  msa_pkg::state_t              state_r, state_nxt;
  logic [msa_pkg::SENSORS-1:0]  vld_r;
  logic                         vld_q_r;
  logic                         out_valid_r;

  // Datapath registers
  msa_pkg::in_item_t            item_r;
  msa_pkg::entry_t              ent_r;
  logic signed [msa_pkg::SAMPLE_BITS-1:0] mean_r;
  msa_pkg::out_item_t           out_r;

  // Memory and divider hookup
  logic                         ram_re, ram_we;
  logic [msa_pkg::ADDR_W-1:0]   in_addr, item_addr;
  logic [EW-1:0]                ram_rdata;
  msa_pkg::entry_t              cur_ent, wr_ent;
  logic                         div_start, div_done;
  logic signed [msa_pkg::SUM_W-1:0] div_quot;

  // Decoded controls
  logic in_fire, in_range, in_needs_read, in_clear;
  logic sample_ok, out_free, load_out, capture_ent;
  msa_pkg::out_item_t result;

  assign in_fire   = in_valid && !in_stall;
  assign in_range  = 32'(in_data.sensor_index) < msa_pkg::SENSORS;
  assign in_addr   = msa_pkg::ADDR_W'(in_data.sensor_index);
  assign item_addr = msa_pkg::ADDR_W'(item_r.sensor_index);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    in_needs_read = 1'b0;
    in_clear      = 1'b0;
    unique case (in_data.kind) inside
      msa_pkg::KIND_SAMPLE,
      msa_pkg::KIND_EVAL:  in_needs_read = in_range;
      msa_pkg::KIND_CLEAR: in_clear      = in_range;
      default: ;
    endcase
  end

  // Entry never written since reset or last clear reads as empty
  assign cur_ent   = vld_q_r ? msa_pkg::entry_t'(ram_rdata) : msa_pkg::ENTRY_EMPTY;
  assign sample_ok = (cur_ent.cnt < limit_r);

  always_comb begin
    wr_ent     = cur_ent;
    wr_ent.cnt = cur_ent.cnt + 1'b1;
    wr_ent.sum = cur_ent.sum + msa_pkg::SUM_W'(item_r.strain);
    if (item_r.strain > cur_ent.mx) begin
      wr_ent.mx = item_r.strain;
    end
    if (item_r.strain < cur_ent.mn) begin
      wr_ent.mn = item_r.strain;
    end
  end

  msa_ram #(
    .WIDTH (EW),
    .DEPTH (msa_pkg::SENSORS)
  ) u_stats_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item_addr),
    .wdata (wr_ent),
    .re    (ram_re),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  msa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cur_ent.sum),
    .divisor  (cur_ent.cnt),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      msa_pkg::ST_IDLE: begin
        if (in_fire && in_needs_read) begin
          state_nxt = msa_pkg::ST_READ;
        end
      end
      msa_pkg::ST_READ: begin
        if (item_r.kind == msa_pkg::KIND_EVAL) begin
          state_nxt = (cur_ent.cnt == '0) ? msa_pkg::ST_RESP : msa_pkg::ST_DIV;
        end else begin
          state_nxt = msa_pkg::ST_IDLE;
        end
      end
      msa_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = msa_pkg::ST_RESP;
        end
      end
      msa_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = msa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msa_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall    = 1'b1;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    div_start   = 1'b0;
    capture_ent = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      msa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        ram_re   = in_valid && in_needs_read;
      end
      msa_pkg::ST_READ: begin
        if (item_r.kind == msa_pkg::KIND_EVAL) begin
          capture_ent = 1'b1;
          div_start   = (cur_ent.cnt != '0);
        end else begin
          ram_we = sample_ok;
        end
      end
      msa_pkg::ST_DIV: ;
      msa_pkg::ST_RESP: load_out = out_free;
      default: ;
    endcase
  end

  // Assemble the result; empty sensor reports zeros
  always_comb begin
    result.sensor_out   = item_r.sensor_index;
    result.sample_count = ent_r.cnt;
    if (ent_r.cnt == '0) begin
      result.peak_strain   = '0;
      result.trough_strain = '0;
      result.mean_strain   = '0;
      result.high_alert    = 1'b0;
      result.empty_res     = 1'b1;
    end else begin
      result.peak_strain   = ent_r.mx;
      result.trough_strain = ent_r.mn;
      result.mean_strain   = mean_r;
      result.high_alert    = (ent_r.mx > thr_r);
      result.empty_res     = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msa_pkg::ST_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= msa_pkg::THR_W'(1280);
      limit_r     <= msa_pkg::CNT_W'(100);
    end else begin
      state_r <= state_nxt;
      if (in_fire && in_clear) begin
        vld_r[in_addr] <= 1'b0;
      end
      if (ram_we) begin
        vld_r[item_addr] <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          msa_pkg::CFG_THRESH: thr_r   <= cfg_data[msa_pkg::THR_W-1:0];
          msa_pkg::CFG_LIMIT:  limit_r <= cfg_data[msa_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ram_re) begin
      item_r  <= in_data;
      vld_q_r <= vld_r[in_addr];
    end
    if (capture_ent) begin
      ent_r <= cur_ent;
    end
    if (div_done) begin
      mean_r <= div_quot[msa_pkg::SAMPLE_BITS-1:0];
    end
    if (load_out) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_read_follows_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == msa_pkg::ST_READ |-> $past(state_r) == msa_pkg::ST_IDLE)
    else $error("read cycle without an accepted item");

  a_div_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == msa_pkg::ST_DIV)
    else $error("divider finished outside the divide wait");

  a_count_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> wr_ent.cnt <= limit_r && wr_ent.cnt != '0)
    else $error("write-back exceeds sample limit");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == msa_pkg::ST_RESP)
    else $error("result appeared without an evaluate");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_r))
    else $error("stalled result lost or changed");

endmodule

FILE: src/msa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module msa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/msa_div.sv
// Bit-serial signed-by-unsigned divider, quotient truncated toward zero.
// Depends on msa_pkg for SUM_W and CNT_W.
module msa_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [msa_pkg::SUM_W-1:0] dividend,
  input  logic [msa_pkg::CNT_W-1:0]       divisor,
  output logic                            done,
  output logic signed [msa_pkg::SUM_W-1:0] quotient
);

  localparam int SW     = msa_pkg::SUM_W;
  localparam int CW     = msa_pkg::CNT_W;
  localparam int STEP_W = $clog2(SW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [SW-1:0]     quot_r, quot_nxt;
  logic [CW-1:0]     dvs_r, dvs_nxt;
  logic              neg_r, neg_nxt;

  logic [CW:0]       shifted;
  logic [CW:0]       diff;
  logic              ge;

  // One quotient bit a cycle
  always_comb begin
    shifted = {rem_r, quot_r[SW-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = (shifted >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(SW - 1);
      rem_nxt  = '0;
      quot_nxt = dividend[SW-1] ? SW'(-dividend) : dividend;
      dvs_nxt  = divisor;
      neg_nxt  = dividend[SW-1];
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[CW-1:0] : shifted[CW-1:0];
      quot_nxt = {quot_r[SW-2:0], ge};
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? $signed(SW'(-quot_r)) : $signed(quot_r);

endmodule

FILE: sim/msa_stats_checker.sv
// Scoreboard for the strain statistics unit: tracks every sensor's statistics
// from the items the unit accepts and checks each report it sends back.
// Depends on msa_pkg.
module msa_stats_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  msa_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  msa_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [msa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msa_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);

  localparam logic signed [msa_pkg::THR_W-1:0] THRESH_RESET = 16'sd1280;
  localparam logic [msa_pkg::CNT_W-1:0]        LIMIT_RESET  = 7'd100;

  // Per-sensor statistics as the unit should hold them
  logic [msa_pkg::CNT_W-1:0]              sample_cnt [msa_pkg::SENSORS];
  int                                     strain_sum [msa_pkg::SENSORS];
  logic signed [msa_pkg::SAMPLE_BITS-1:0] strain_min [msa_pkg::SENSORS];
  logic signed [msa_pkg::SAMPLE_BITS-1:0] strain_max [msa_pkg::SENSORS];
  logic signed [msa_pkg::THR_W-1:0]       alert_thresh;
  logic [msa_pkg::CNT_W-1:0]              sample_limit;

  // Reports owed by the unit, oldest first
  msa_pkg::out_item_t report_q [$];

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want, input int sensor);
    if (got !== want)
      report($sformatf("sensor %0d %s got %0d expected %0d", sensor, name, got, want));
  endtask

  task automatic empty_sensor(input int s);
    sample_cnt[s] = '0;
    strain_sum[s] = 0;
    strain_min[s] = msa_pkg::SMAX;
    strain_max[s] = msa_pkg::SMIN;
  endtask

  // Update one sensor for an accepted item; queue a report for an evaluate.
  task automatic update_stats(input msa_pkg::in_item_t it);
    int s;
    logic signed [msa_pkg::SAMPLE_BITS-1:0] v;
    msa_pkg::out_item_t r;
    s = int'(it.sensor_index);
    v = it.strain;
    r = '0;
    if (s < msa_pkg::SENSORS) begin
      case (it.kind)
        msa_pkg::KIND_SAMPLE: begin
          // drop samples once the sensor is full, also after a lowered limit
          if (sample_cnt[s] < sample_limit) begin
            sample_cnt[s] = sample_cnt[s] + 1'b1;
            strain_sum[s] += int'(v);
            if (v > strain_max[s]) strain_max[s] = v;
            if (v < strain_min[s]) strain_min[s] = v;
          end
        end
        msa_pkg::KIND_CLEAR: empty_sensor(s);
        msa_pkg::KIND_EVAL: begin
          r.sensor_out   = it.sensor_index;
          r.sample_count = sample_cnt[s];
          if (sample_cnt[s] == '0) begin
            r.empty_res = 1'b1;
          end else begin
            r.peak_strain   = strain_max[s];
            r.trough_strain = strain_min[s];
            r.mean_strain   = 16'(strain_sum[s] / int'(sample_cnt[s]));
            r.high_alert    = (strain_max[s] > alert_thresh);
          end
          report_q.push_back(r);
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin
    msa_pkg::out_item_t want;
    if (!rst_n) begin
      for (int s = 0; s < msa_pkg::SENSORS; s++) empty_sensor(s);
      alert_thresh = THRESH_RESET;
      sample_limit = LIMIT_RESET;
      report_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == msa_pkg::CFG_THRESH) alert_thresh = cfg_data[msa_pkg::THR_W-1:0];
        else if (cfg_index == msa_pkg::CFG_LIMIT) sample_limit = cfg_data[msa_pkg::CNT_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          report($sformatf("unexpected report for sensor %0d", out_data.sensor_out));
        end else begin
          want = report_q.pop_front();
          check_field("sensor_out", out_data.sensor_out, want.sensor_out,
                      want.sensor_out);
          check_field("peak_strain", $signed(out_data.peak_strain),
                      $signed(want.peak_strain), want.sensor_out);
          check_field("trough_strain", $signed(out_data.trough_strain),
                      $signed(want.trough_strain), want.sensor_out);
          check_field("mean_strain", $signed(out_data.mean_strain),
                      $signed(want.mean_strain), want.sensor_out);
          check_field("sample_count", out_data.sample_count, want.sample_count,
                      want.sensor_out);
          check_field("high_alert", out_data.high_alert, want.high_alert,
                      want.sensor_out);
          check_field("empty_res", out_data.empty_res, want.empty_res,
                      want.sensor_out);
        end
      end
      if (in_valid && !in_stall) update_stats(in_data);
    end
    pending = report_q.size();
  end

endmodule

FILE: sim/tb_multichannel_strain_stats_alert_unit.sv
// Testbench top for the strain statistics unit: drives sample, evaluate, clear
// and unknown-kind items plus register writes, and gives the verdict.
// Depends on msa_pkg, msa_stats_checker and the unit itself.
module tb_multichannel_strain_stats_alert_unit;

  // The one kind code the unit must drop without a report
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Idle wait after draining, so trailing work finishes before a register write
  localparam int SETTLE_CYCLES  = 40;
  // Cycles with no item moving on either channel before giving up
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 130;

  logic                             clk;
  logic                             rst_n     = 1'b0;
  logic                             in_valid  = 1'b0;
  logic                             in_stall;
  msa_pkg::in_item_t                in_data   = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  msa_pkg::out_item_t               out_data;
  logic                             cfg_we    = 1'b0;
  logic [msa_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [msa_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;
  int                               fail_count;
  int                               pending;

  // Idle odds in percent for each side; zero gives a flat-out stretch
  int                               gap_pct   = 35;
  int                               stall_pct = 35;
  int                               quiet_cycles = 0;
  logic signed [msa_pkg::THR_W-1:0] cur_thresh = 16'sd1280;

  multichannel_strain_stats_alert_unit u_top (.*);
  msa_stats_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: stall at random, changed on the falling edge only
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: count cycles where neither channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, idling first at random, and hold it until accepted.
  // Leave valid high on return; a gap in the next call or a drain lowers it.
  task automatic send_item(input logic [1:0] k,
                           input logic [msa_pkg::SENSOR_W-1:0] idx,
                           input logic signed [msa_pkg::SAMPLE_BITS-1:0] value);
    msa_pkg::in_item_t it;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    it.kind         = k;
    it.sensor_index = idx;
    it.strain       = value;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold off the sender until every owed report has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Drain, then let a trailing sample or clear finish before a register write.
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both registers on back-to-back cycles.
  task automatic write_config(input logic signed [msa_pkg::THR_W-1:0] thr,
                              input logic [msa_pkg::CNT_W-1:0] lim);
    cur_thresh = thr;
    cfg_we    <= 1'b1;
    cfg_index <= msa_pkg::CFG_THRESH;
    cfg_data  <= thr;
    @(negedge clk);
    cfg_index <= msa_pkg::CFG_LIMIT;
    cfg_data  <= {{(msa_pkg::CFG_DATA_W-msa_pkg::CNT_W){1'b0}}, lim};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Strain values: extremes, values around the threshold, and full-range noise.
  function automatic logic signed [msa_pkg::SAMPLE_BITS-1:0] pick_strain();
    case ($urandom_range(9))
      0:       return msa_pkg::SMAX;
      1:       return msa_pkg::SMIN;
      2:       return 16'sd0;
      3:       return -16'sd1;
      4, 5:    return cur_thresh + 16'($urandom_range(4)) - 16'd2;
      default: return 16'($urandom);
    endcase
  endfunction

  // One phase: new register settings, then a burst of items aimed at a small
  // pool of sensors so counts climb toward the limit between clears.
  task automatic run_phase(input int p);
    logic signed [msa_pkg::THR_W-1:0] thr;
    logic [msa_pkg::CNT_W-1:0]        lim;
    logic [1:0]                       k;
    logic [msa_pkg::SENSOR_W-1:0]     idx;
    int                               pool, base, samp_pct, clr_pct, n_items, r;
    thr       = 16'($urandom);
    lim       = 7'($urandom_range(127, 1));
    pool      = 8;
    samp_pct  = 60;
    clr_pct   = 5;
    n_items   = PHASE_ITEMS;
    gap_pct   = 35;
    stall_pct = 35;
    case (p)
      // fill one sensor past the widest limit
      0: begin thr = 16'sd1280; lim = 7'd127; pool = 1; samp_pct = 85;
               clr_pct = 0; n_items = 180; end
      1: begin thr = msa_pkg::SMIN; lim = 7'd1; end
      2: begin thr = msa_pkg::SMAX; lim = 7'd3; pool = 2; end
      // run flat out on both sides
      3: begin gap_pct = 0; stall_pct = 0; end
      4: begin thr = 16'sd0; lim = 7'd20; pool = 1; samp_pct = 80; clr_pct = 1; end
      default: ;
    endcase
    settle();
    write_config(thr, lim);
    base = $urandom_range(63);
    repeat (n_items) begin
      r = $urandom_range(99);
      if (r < samp_pct)          k = msa_pkg::KIND_SAMPLE;
      else if (r < 95 - clr_pct) k = msa_pkg::KIND_EVAL;
      else if (r < 95)           k = msa_pkg::KIND_CLEAR;
      else                       k = KIND_NONE;
      if ($urandom_range(9) == 0) idx = 6'($urandom_range(63));
      else                        idx = 6'(base + $urandom_range(pool - 1));
      send_item(k, idx, (k == msa_pkg::KIND_SAMPLE) ? pick_strain() : 16'($urandom));
      // now and then hold off until the unit has answered everything
      if ($urandom_range(59) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Empty sensor, then full-range extremes on one sensor
    send_item(msa_pkg::KIND_EVAL,   6'd0,  16'sd0);
    send_item(msa_pkg::KIND_SAMPLE, 6'd0,  msa_pkg::SMAX);
    send_item(msa_pkg::KIND_SAMPLE, 6'd0,  msa_pkg::SMIN);
    send_item(msa_pkg::KIND_EVAL,   6'd0,  16'sd0);
    // Negative mean that truncates toward zero, on the top sensor
    send_item(msa_pkg::KIND_SAMPLE, 6'd63, -16'sd1);
    send_item(msa_pkg::KIND_SAMPLE, 6'd63, -16'sd2);
    send_item(msa_pkg::KIND_EVAL,   6'd63, 16'sd0);
    // Unknown kind must leave the sensor empty
    send_item(KIND_NONE,            6'd5,  msa_pkg::SMAX);
    send_item(msa_pkg::KIND_EVAL,   6'd5,  16'sd0);
    // Clear returns a sensor to empty
    send_item(msa_pkg::KIND_CLEAR,  6'd0,  16'sd0);
    send_item(msa_pkg::KIND_EVAL,   6'd0,  16'sd0);
    // Alert only when the maximum is strictly above the threshold
    send_item(msa_pkg::KIND_SAMPLE, 6'd1,  16'sd1280);
    send_item(msa_pkg::KIND_EVAL,   6'd1,  16'sd0);
    send_item(msa_pkg::KIND_SAMPLE, 6'd1,  16'sd1281);
    send_item(msa_pkg::KIND_EVAL,   6'd1,  16'sd0);
    send_item(msa_pkg::KIND_CLEAR,  6'd63, 16'sd0);
    send_item(msa_pkg::KIND_EVAL,   6'd63, 16'sd0);

    // Lowest threshold, limit of one: a full sensor and a limit below the count
    settle();
    write_config(msa_pkg::SMIN, 7'd1);
    send_item(msa_pkg::KIND_SAMPLE, 6'd2,  msa_pkg::SMIN);
    send_item(msa_pkg::KIND_SAMPLE, 6'd2,  16'sd100);
    send_item(msa_pkg::KIND_EVAL,   6'd2,  16'sd0);
    send_item(msa_pkg::KIND_SAMPLE, 6'd1,  16'sd5);
    send_item(msa_pkg::KIND_EVAL,   6'd1,  16'sd0);

    // Highest threshold, limit of zero: every sample dropped
    settle();
    write_config(msa_pkg::SMAX, 7'd0);
    send_item(msa_pkg::KIND_SAMPLE, 6'd3,  16'sd7);
    send_item(msa_pkg::KIND_EVAL,   6'd3,  16'sd0);
    send_item(msa_pkg::KIND_EVAL,   6'd1,  16'sd0);

    for (int p = 0; p < PHASES; p++) run_phase(p);

    // Wait for the last reports, then give trailing work time to show up
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
